// ===== src/npp_pkg.sv =====
// Shared types and constants for the nearest point on polyline block.
package npp_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PCOUNT_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USE_QUERY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 8'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] anchor_x;
    logic signed [COORD_W-1:0] anchor_y;
    logic                      found;
  } out_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MID  = 2'd1,
    OP_SEG  = 2'd2
  } op_t;

  // one classified vertex handed from front to back
  typedef struct packed {
    op_t                       op;
    logic                      first;
    logic                      last;
    logic                      found;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } item_t;

  // magnitude of a 33-bit signed value; -2^32 maps to 2^32
  function automatic logic [COORD_W:0] mag33(input logic signed [COORD_W:0] v);
    logic [COORD_W:0] r;
    r = v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
    return r;
  endfunction

endpackage

// ===== src/nearest_point_on_polyline.sv =====
// Top level of the nearest point on polyline block: config registers and wiring.
//
//   channel   handshake           payload
//   input     push / full         in_data   (vertex_x, vertex_y, last_vertex)
//   result    pop / empty         out_data  (anchor_x, anchor_y, found)
//   config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// A segment request passes through the back end as a pop in S_IDLE, a
// dot-product pass (S_DOT), a classify step (S_CLASS), the restoring divider
// (S_DIV) when t is not clamped, two passes (S_SCALE, S_DIST) through the one
// shared multiplier that S_DOT also uses, and a finish step (S_FIN). Other
// vertices go from S_IDLE to S_FIN. Four classified requests queue between the
// front and back ends, so push stalls only when that queue fills; a finished
// result waits in the output register while work goes on. Reset is
// synchronous and clears all control state; config is always ready.
module nearest_point_on_polyline
  import npp_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                      use_query;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic [PCOUNT_W-1:0]       point_count;

  logic  accept;
  item_t f_item;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      use_query   <= 1'b0;
      query_x     <= '0;
      query_y     <= '0;
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_USE_QUERY:   use_query   <= cfg_data[0];
        REG_QUERY_X:     query_x     <= cfg_data;
        REG_QUERY_Y:     query_y     <= cfg_data;
        REG_POINT_COUNT: point_count <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  npp_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_data     (in_data),
    .use_query   (use_query),
    .point_count (point_count),
    .item        (f_item)
  );

  npp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_item (f_item),
    .full    (full),
    .rd      (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  npp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .query_x  (query_x),
    .query_y  (query_y),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== src/npp_front.sv =====
// Front end: tracks vertex index and previous vertex, classifies each vertex.
module npp_front
  import npp_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  in_t                 in_data,
  input  logic                use_query,
  input  logic [PCOUNT_W-1:0] point_count,
  output item_t               item
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int MW = (CW > PCOUNT_W) ? CW : PCOUNT_W;

  logic [CW-1:0]             vertices_seen;
  logic [CW-1:0]             vertices_seen_next;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic                      is_mid;

  assign is_mid = MW'(vertices_seen) == MW'(point_count >> 1);

  always_comb begin
    item.ax    = prev_x;
    item.ay    = prev_y;
    item.bx    = in_data.vertex_x;
    item.by    = in_data.vertex_y;
    item.last  = in_data.last_vertex;
    item.found = vertices_seen != '0;
    item.first = vertices_seen == CW'(1);
    if (use_query) begin
      item.op = (vertices_seen != '0) ? OP_SEG : OP_NONE;
    end else begin
      item.op = is_mid ? OP_MID : OP_NONE;
    end
  end

  assign vertices_seen_next = (vertices_seen < CW'(MAX_POINTS)) ?
                              vertices_seen + CW'(1) : CW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_seen <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
    end else if (accept) begin
      if (in_data.last_vertex) begin
        vertices_seen <= '0;
        prev_x        <= '0;
        prev_y        <= '0;
      end else begin
        vertices_seen <= vertices_seen_next;
        prev_x        <= in_data.vertex_x;
        prev_y        <= in_data.vertex_y;
      end
    end
  end

endmodule

// ===== src/npp_queue.sv =====
// Short queue of classified vertices between front and back.
module npp_queue
  import npp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full    = count == (PW+1)'(DEPTH);
  assign empty   = count == '0;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + PW'(1);
      if (rd) rptr <= rptr + PW'(1);
      if (wr && !rd) begin
        count <= count + (PW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== src/npp_back.sv =====
// Back end: projection, serial divide, distance compare and result register.
module npp_back
  import npp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  item_t                     q_item,
  output logic                      q_pop,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_y,
  output logic                      empty,
  input  logic                      pop,
  output out_t                      out_data
);

  localparam int TW = FRAC_BITS + 1;
  localparam int SW = $clog2(FRAC_BITS + 1);
  localparam int DW = COORD_W + 1;      // difference width
  localparam int PW = 2 * DW;           // product width
  localparam int LW = PW + 1;           // sum of two products
  localparam int RW = LW + 1;           // remainder
  localparam int NW = RW + 1;           // signed numerator
  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DOT   = 7'b0000010,
    S_CLASS = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIST  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                    state;
  logic [SW-1:0]             step;
  logic                      first, last, found;
  logic signed [COORD_W-1:0] ax, ay, qx, qy, px, py;
  logic signed [DW-1:0]      dx, dy, ex, ey;
  logic [LW-1:0]             len2;
  logic signed [NW-1:0]      num;
  logic [RW-1:0]             rem;
  logic [TW-1:0]             t;
  logic [PW-1:0]             prod;
  logic [LW-1:0]             dsum;
  logic signed [COORD_W-1:0] best_x, best_y;
  logic [63:0]               best_dist;
  logic                      out_valid;

  logic [DW-1:0]        mul_a, mul_b;
  logic [DW-1:0]        mdx, mdy, mex, mey, mddx, mddy;
  logic [RW-1:0]        rem2;
  logic                 div_ge;
  logic [PW-1:0]        rsum;
  logic [DW-1:0]        qmag;
  logic                 sc_neg;
  logic signed [COORD_W-1:0] sc_base;
  logic signed [COORD_W+1:0] sc_pos;
  logic [LW-1:0]        dist_full;
  logic [63:0]          d2;

  assign mdx  = mag33(dx);
  assign mdy  = mag33(dy);
  assign mex  = mag33(ex);
  assign mey  = mag33(ey);
  assign mddx = mag33(DW'(px) - DW'(qx));
  assign mddy = mag33(DW'(py) - DW'(qy));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DOT: begin
        case (step)
          SW'(0): begin mul_a = mdx; mul_b = mdx; end
          SW'(1): begin mul_a = mdy; mul_b = mdy; end
          SW'(2): begin mul_a = mex; mul_b = mdx; end
          default: begin mul_a = mey; mul_b = mdy; end
        endcase
      end
      S_SCALE: begin
        mul_a = DW'(t);
        mul_b = (step == '0) ? mdx : mdy;
      end
      S_DIST: begin
        mul_a = (step == '0) ? mddx : mddy;
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rem2   = {rem[RW-2:0], 1'b0};
  assign div_ge = rem2 >= RW'(len2);

  // t*|d| rounded half away from zero, then applied with the sign of d
  assign rsum    = prod + (PW'(1) << (FRAC_BITS - 1));
  assign qmag    = DW'(rsum >> FRAC_BITS);
  assign sc_neg  = (step == SW'(1)) ? dx[DW-1] : dy[DW-1];
  assign sc_base = (step == SW'(1)) ? ax : ay;
  assign sc_pos  = sc_neg ? (COORD_W+2)'(sc_base) - (COORD_W+2)'(qmag)
                          : (COORD_W+2)'(sc_base) + (COORD_W+2)'(qmag);

  assign dist_full = dsum + LW'(prod);
  assign d2        = (dist_full[LW-1:64] != '0) ? '1 : dist_full[63:0];

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      best_x    <= '0;
      best_y    <= '0;
      best_dist <= '1;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded in S_FIN takes the place of the one popped
      if (pop && out_valid && !(state == S_FIN && last)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            first <= q_item.first;
            last  <= q_item.last;
            found <= q_item.found;
            ax    <= q_item.ax;
            ay    <= q_item.ay;
            qx    <= query_x;
            qy    <= query_y;
            dx    <= DW'(q_item.bx) - DW'(q_item.ax);
            dy    <= DW'(q_item.by) - DW'(q_item.ay);
            ex    <= DW'(query_x) - DW'(q_item.ax);
            ey    <= DW'(query_y) - DW'(q_item.ay);
            len2  <= '0;
            num   <= '0;
            step  <= '0;
            case (q_item.op)
              OP_SEG: state <= S_DOT;
              OP_MID: begin
                best_x <= q_item.bx;
                best_y <= q_item.by;
                state  <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_DOT: begin
          step <= step + SW'(1);
          case (step)
            SW'(1), SW'(2): len2 <= len2 + LW'(prod);
            SW'(3): num <= (ex[DW-1] ^ dx[DW-1]) ? num - NW'(prod) : num + NW'(prod);
            SW'(4): begin
              num   <= (ey[DW-1] ^ dy[DW-1]) ? num - NW'(prod) : num + NW'(prod);
              state <= S_CLASS;
            end
            default: ;
          endcase
        end
        S_CLASS: begin
          step <= '0;
          if (len2 == '0 || num[NW-1] || num == '0) begin
            t     <= '0;
            state <= S_SCALE;
          end else if (num[RW-1:0] >= RW'(len2)) begin
            t     <= T_ONE;
            state <= S_SCALE;
          end else begin
            t     <= '0;
            rem   <= num[RW-1:0];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? rem2 - RW'(len2) : rem2;
          t   <= {t[TW-2:0], div_ge};
          if (step == SW'(FRAC_BITS - 1)) begin
            step  <= '0;
            state <= S_SCALE;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_SCALE: begin
          if (step == SW'(1)) px <= COORD_W'(sc_pos);
          if (step == SW'(2)) begin
            py    <= COORD_W'(sc_pos);
            step  <= '0;
            state <= S_DIST;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_DIST: begin
          if (step == SW'(1)) dsum <= LW'(prod);
          if (step == SW'(2)) begin
            if (first || d2 < best_dist) begin
              best_dist <= d2;
              best_x    <= px;
              best_y    <= py;
            end
            state <= S_FIN;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!out_valid || pop) begin
            out_valid         <= 1'b1;
            out_data.anchor_x <= found ? best_x : '0;
            out_data.anchor_y <= found ? best_y : '0;
            out_data.found    <= found;
            best_x            <= '0;
            best_y            <= '0;
            best_dist         <= '1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for nearest_point_on_polyline: queued vertex stream, in-line prediction, checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npp_pkg::*;

  localparam int FRAC = 16;            // fraction bits of t, matches the block default
  localparam int MAX_PTS = 1024;       // vertex counter saturation
  localparam int SETTLE = 80;          // cycles allowed after the last result

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nearest_point_on_polyline u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // vertex requests waiting to be driven, anchors waiting to come out
  in_t vertex_queue[$];
  out_t anchor_queue[$];
  int mismatches = 0;
  int vertices_sent = 0;

  // shadow registers
  bit query_mode = 1'b0;
  logic signed [31:0] qry_x = '0;
  logic signed [31:0] qry_y = '0;
  bit [10:0] vcount = '0;

  // shadow polyline tracker
  longint last_x, last_y, pick_x, pick_y;
  bit [63:0] pick_d2;
  int seen_cnt;

  function automatic void restart_track();
    last_x = 0; last_y = 0; pick_x = 0; pick_y = 0;
    pick_d2 = '1;
    seen_cnt = 0;
  endfunction

  // t*d / 2^FRAC, rounded half away from zero
  function automatic longint frac_offset(longint t, logic signed [127:0] d);
    logic [127:0] p;
    logic [127:0] q;
    p = t * (d < 0 ? -d : d);
    q = (p + (128'd1 << (FRAC - 1))) >> FRAC;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  // project the query point onto segment a->b and keep it if closer
  function automatic void project_segment(longint ax, longint ay, longint bx, longint by,
                                          bit first);
    logic signed [127:0] dx, dy, ex, ey, len2, dot, ddx, ddy, dsq;
    longint t, px, py;
    bit [63:0] d2;
    dx = bx - ax;
    dy = by - ay;
    ex = longint'(qry_x) - ax;
    ey = longint'(qry_y) - ay;
    len2 = dx * dx + dy * dy;
    dot = ex * dx + ey * dy;
    t = 0;
    // clamp: behind the start gives 0, past the end gives 1.0; zero length keeps 0
    if (len2 != 0 && dot > 0)
      t = (dot >= len2) ? (longint'(1) << FRAC) : longint'((dot <<< FRAC) / len2);
    px = ax + frac_offset(t, dx);
    py = ay + frac_offset(t, dy);
    ddx = px - longint'(qry_x);
    ddy = py - longint'(qry_y);
    dsq = ddx * ddx + ddy * ddy;
    d2 = (dsq >>> 64) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : dsq[63:0];
    // strict compare so a tie keeps the earlier point
    if (first || d2 < pick_d2) begin
      pick_d2 = d2;
      pick_x = px;
      pick_y = py;
    end
  endfunction

  // returns 1 when the vertex closes a polyline and yields an anchor
  function automatic bit predict_anchor(in_t v, output out_t r);
    longint x, y;
    int idx;
    x = longint'(v.vertex_x);
    y = longint'(v.vertex_y);
    idx = seen_cnt;
    r = '0;
    if (query_mode) begin
      if (idx >= 1) project_segment(last_x, last_y, x, y, idx == 1);
    end else if (idx == int'(vcount / 2)) begin
      pick_x = x;
      pick_y = y;
    end
    last_x = x;
    last_y = y;
    seen_cnt = idx < MAX_PTS ? idx + 1 : MAX_PTS;
    if (!v.last_vertex) return 1'b0;
    if (idx + 1 >= 2) begin
      r.anchor_x = pick_x[31:0];
      r.anchor_y = pick_y[31:0];
      r.found = 1'b1;
    end
    restart_track();
    return 1'b1;
  endfunction

  // driver: bursts of requests with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin : drive_vertices
    out_t r;
    if (rst) begin
      push <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (push && !full) begin
        if (predict_anchor(in_data, r)) anchor_queue = {anchor_queue, r};
      end
      if (push && full) begin
        // request not taken yet, hold it
      end else if (gap_left > 0) begin
        push <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (vertex_queue.size() > 0) begin
        in_data <= vertex_queue[0];
        vertex_queue.delete(0);
        push <= 1'b1;
        vertices_sent <= vertices_sent + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: pop with a stall rate that is redrawn whenever its random hold-off counter runs out
  int stall_pct = 0;
  int stall_left = 0;
  always @(posedge clk) begin : check_anchors
    out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (anchor_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected anchor x=%h y=%h found=%b",
                                        out_data.anchor_x, out_data.anchor_y, out_data.found);
        end else begin
          want = anchor_queue[0];
          anchor_queue.delete(0);
          if (out_data !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("anchor mismatch: exp x=%h y=%h found=%b, got x=%h y=%h found=%b",
                       want.anchor_x, want.anchor_y, want.found,
                       out_data.anchor_x, out_data.anchor_y, out_data.found);
          end
        end
      end
      if (stall_left == 0) begin
        stall_left <= $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          2: stall_pct <= 70;
          default: stall_pct <= 95;
        endcase
      end else begin
        stall_left <= stall_left - 1;
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one config request; shadow copy follows at the accepting edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_USE_QUERY:   query_mode = val[0];
      REG_QUERY_X:     qry_x = val;
      REG_QUERY_Y:     qry_y = val;
      REG_POINT_COUNT: vcount = val[10:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(bit mode, logic [31:0] x, logic [31:0] y, logic [10:0] cnt);
    write_reg(REG_USE_QUERY, {31'd0, mode});
    write_reg(REG_QUERY_X, x);
    write_reg(REG_QUERY_Y, y);
    write_reg(REG_POINT_COUNT, {21'd0, cnt});
  endtask

  // sender holds off until every anchor is back and the back end has drained
  task automatic drain();
    do @(negedge clk); while (vertex_queue.size() != 0 || push || anchor_queue.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, bit last);
    in_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.last_vertex = last;
    vertex_queue = {vertex_queue, v};
  endtask

  // extremes, full-range noise, or a point near the given center
  function automatic logic [31:0] pick_coord(logic [31:0] near);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return near + $urandom_range(0, 4000000) - 2000000;
    endcase
  endfunction

  task automatic add_polyline(int n);
    logic [31:0] x, y;
    x = pick_coord(qry_x);
    y = pick_coord(qry_y);
    for (int i = 0; i < n; i++) begin
      // repeated vertex now and then gives a zero-length segment
      if (i == 0 || $urandom_range(0, 7) != 0) begin
        x = pick_coord(x);
        y = pick_coord(y);
      end
      add_vertex(x, y, i == n - 1);
    end
  endtask

  initial begin : stimulus
    int n;
    restart_track();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: query at origin
    setup(1'b1, 32'd0, 32'd0, 11'd0);
    add_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);        // full-range diagonal
    add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_vertex(32'd5, 32'd5, 1'b0);                        // zero-length segment
    add_vertex(32'd5, 32'd5, 1'b1);
    add_vertex(32'd9, 32'd9, 1'b1);                        // single vertex: not found
    add_vertex(-32'sd65536, 32'd65536, 1'b0);              // equal distances: earlier wins
    add_vertex(32'd65536, 32'd65536, 1'b0);
    add_vertex(32'd65536, -32'sd65536, 1'b1);
    drain();
    // query at one corner, polyline at the other: saturated distance
    setup(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 11'd0);
    add_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_vertex(32'h8000_0000, 32'h8000_0001, 1'b0);
    add_vertex(32'h8000_0000, 32'h8000_0000, 1'b1);
    drain();
    // midpoint mode: hit, never reached, index zero
    setup(1'b0, 32'h8000_0000, 32'h8000_0000, 11'd5);
    for (int i = 0; i < 5; i++) add_vertex($urandom, $urandom, i == 4);
    drain();
    setup(1'b0, 32'd0, 32'd0, 11'd20);
    for (int i = 0; i < 3; i++) add_vertex($urandom, $urandom, i == 2);
    drain();
    write_reg(8'd200, 32'hFFFF_FFFF);                       // unmapped index, ignored
    setup(1'b0, 32'd0, 32'd0, 11'd0);
    for (int i = 0; i < 4; i++) add_vertex($urandom, $urandom, i == 3);
    drain();

    // random phases
    for (int ph = 0; vertices_sent < 1700; ph++) begin
      setup($urandom_range(0, 1), pick_coord(32'd0), pick_coord(32'd0),
            ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 16)));
      if (ph % 5 == 4) write_reg(8'($urandom_range(4, 255)), $urandom);
      if (ph == 3) begin
        // counter saturation on one long polyline
        write_reg(REG_USE_QUERY, 32'd1);
        add_polyline(1030);
      end
      repeat ($urandom_range(10, 25)) begin
        case ($urandom_range(0, 19))
          0: n = 1;
          1: n = $urandom_range(9, 40);
          default: n = $urandom_range(2, 8);
        endcase
        add_polyline(n);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #12ms;
    $display("Verification failed");
    $finish;
  end

endmodule
